// ----- rtl/tss_pkg.sv -----
package tss_pkg;

    localparam int MAX_VARS  = 1024;
    localparam int MAX_EDGES = 16384;
    localparam int NVERT     = 2 * MAX_VARS;

    localparam int VW  = $clog2(NVERT);        // vertex index
    localparam int NW  = $clog2(MAX_VARS) + 1; // variable count, num_vars
    localparam int AW  = $clog2(MAX_VARS);     // variable index
    localparam int EIW = $clog2(MAX_EDGES);    // edge index
    localparam int EW  = EIW + 1;              // edge pointer with null
    localparam int CW  = VW + 1;               // vertex counts, visit numbers

    localparam logic [EW-1:0] NULL_EDGE = EW'(MAX_EDGES);
    localparam logic [NW-1:0] NV_MAX    = NW'(MAX_VARS);

    localparam logic [1:0] FUNC_AND  = 2'd0;
    localparam logic [1:0] FUNC_OR   = 2'd1;
    localparam logic [1:0] FUNC_XOR  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] MARK_NEW  = 2'd0;
    localparam logic [1:0] MARK_OPEN = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_ROOT_RD,
        S_ROOT_CHK,
        S_ENTER_RD,
        S_ENTER_WR,
        S_STEP,
        S_EDGE_D,
        S_EDGE_T,
        S_POP_RD,
        S_POP_WR,
        S_AFTER,
        S_PAR,
        S_PAR_D,
        S_CHK_A,
        S_CHK_B,
        S_CHK_C,
        S_RESULT
    } state_t;

endpackage

// ----- rtl/two_sat_solver.sv -----
// 2-SAT solver. Each accepted word may carry one constraint x_a OP x_b = c (AND, OR, XOR)
// and appends two or four implication edges to per-vertex lists; an unused or rejected
// constraint adds no edges, otherwise each edge reads its list head, then writes the edge.
// The word with last set then runs an iterative Tarjan search over 2*num_vars literal
// vertices with stacks held in on-chip RAM, followed by a complement compare of each
// variable's two literals. One result word follows (status nonzero forces
// satisfiable low), then a clearing pass over all 2048 vertices resets the list heads
// and marks; the same pass runs after reset. Input is not taken during solve or
// clearing; num_vars may be written at any time and is meant to change only between
// problems.
module two_sat_solver (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [tss_pkg::NW-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [tss_pkg::AW-1:0] var_a,
    input  logic [tss_pkg::AW-1:0] var_b,
    input  logic                 want_value,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 satisfiable,
    output logic [1:0]           status
);
    import tss_pkg::*;

    state_t state_reg, state_next;

    logic [NW-1:0]  nv_reg, nv_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [VW-1:0]  src_reg [4];
    logic [VW-1:0]  src_next [4];
    logic [VW-1:0]  dst_reg [4];
    logic [VW-1:0]  dst_next [4];
    logic [2:0]     k_reg, k_next;
    logic [1:0]     eidx_reg, eidx_next;
    logic           last_reg, last_next;
    logic [EW-1:0]  et_reg, et_next;
    logic [1:0]     err_reg, err_next;
    logic [CW-1:0]  vc_reg, vc_next;
    logic [CW-1:0]  cc_reg, cc_next;
    logic [CW-1:0]  od_reg, od_next;
    logic [CW-1:0]  wd_reg, wd_next;
    logic [VW-1:0]  u_reg, u_next;
    logic [EW-1:0]  e_reg, e_next;
    logic [CW-1:0]  lowu_reg, lowu_next;
    logic [CW-1:0]  ordu_reg, ordu_next;
    logic [VW-1:0]  v_reg, v_next;
    logic [CW-1:0]  ca_reg, ca_next;
    logic           sat_reg, sat_next;
    logic           ov_reg, ov_next;
    logic           osat_reg, osat_next;
    logic [1:0]     ost_reg, ost_next;

    logic [VW-1:0]  edge_target_mem [MAX_EDGES];
    logic [EW-1:0]  edge_link_mem [MAX_EDGES];
    logic [EW-1:0]  head_mem [NVERT];
    logic [CW-1:0]  order_mem [NVERT];
    logic [CW-1:0]  low_mem [NVERT];
    logic [1:0]     mark_mem [NVERT];
    logic [CW-1:0]  comp_mem [NVERT];
    logic [VW-1:0]  open_mem [NVERT];
    logic [VW+EW-1:0] walk_mem [NVERT];

    logic [VW-1:0]  tgt_q;
    logic [EW-1:0]  link_q, head_q;
    logic [CW-1:0]  order_q, low_q, comp_q;
    logic [1:0]     mark_q;
    logic [VW-1:0]  open_q;
    logic [VW+EW-1:0] walk_q;

    logic           edge_we;
    logic           head_we, order_we, low_we, mark_we, comp_we, open_we, walk_we;
    logic [VW-1:0]  vaddr;
    logic [VW-1:0]  head_wa, order_wa, low_wa, mark_wa, comp_wa;
    logic [EW-1:0]  head_wd;
    logic [CW-1:0]  order_wd, low_wd, comp_wd;
    logic [1:0]     mark_wd;
    logic [VW-1:0]  open_wa, open_ra, open_wd;
    logic [VW-1:0]  walk_wa, walk_ra;
    logic [VW+EW-1:0] walk_wd;

    logic [NW-1:0]  n_act;
    logic [CW-1:0]  two_n;
    logic [VW-1:0]  ta, tb, fa, fb;
    logic [VW-1:0]  es [4];
    logic [VW-1:0]  ed [4];
    logic [2:0]     ek;
    logic           bad_idx;
    logic [EW:0]    et_sum;
    logic           in_acc;

    always_comb
    begin
        if (nv_reg == '0)
            n_act = NW'(1);
        else if (nv_reg > NV_MAX)
            n_act = NV_MAX;
        else
            n_act = nv_reg;
    end

    assign two_n     = {n_act, 1'b0};
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid   = ov_reg;
    assign satisfiable = osat_reg;
    assign status      = ost_reg;

    assign ta = VW'(var_a);
    assign tb = VW'(var_b);
    assign fa = VW'(var_a) + VW'(n_act);
    assign fb = VW'(var_b) + VW'(n_act);
    assign bad_idx = (NW'(var_a) >= n_act) || (NW'(var_b) >= n_act);

    always_comb
    begin
        es[0] = ta; ed[0] = tb; es[1] = tb; ed[1] = ta;
        es[2] = fa; ed[2] = fb; es[3] = fb; ed[3] = fa;
        ek = 3'd4;
        case (func)
            FUNC_AND:
            begin
                if (!want_value)
                begin
                    es[0] = ta; ed[0] = fb; es[1] = tb; ed[1] = fa; ek = 3'd2;
                end
                else
                begin
                    es[2] = fa; ed[2] = ta; es[3] = fb; ed[3] = tb;
                end
            end
            FUNC_OR:
            begin
                if (!want_value)
                begin
                    es[0] = fa; ed[0] = fb; es[1] = fb; ed[1] = fa;
                    es[2] = ta; ed[2] = fa; es[3] = tb; ed[3] = fb;
                end
                else
                begin
                    es[0] = fa; ed[0] = tb; es[1] = fb; ed[1] = ta; ek = 3'd2;
                end
            end
            FUNC_XOR:
            begin
                if (want_value)
                begin
                    es[0] = fa; ed[0] = tb; es[1] = fb; ed[1] = ta;
                    es[2] = ta; ed[2] = fb; es[3] = tb; ed[3] = fa;
                end
            end
            default:
            begin
                ek = 3'd0;
            end
        endcase
    end

    assign et_sum = {1'b0, et_reg} + (EW+1)'(ek);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (cnt_reg == CW'(NVERT - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (in_acc)
                begin
                    if (func != FUNC_NONE && !bad_idx && et_sum <= (EW+1)'(MAX_EDGES))
                        state_next = S_LOAD_RD;
                    else if (last)
                        state_next = S_ROOT_RD;
                end
            S_LOAD_RD:
                state_next = S_LOAD_WR;
            S_LOAD_WR:
                if (3'(eidx_reg) + 3'd1 == k_reg)
                    state_next = last_reg ? S_ROOT_RD : S_IDLE;
                else
                    state_next = S_LOAD_RD;
            S_ROOT_RD:
                state_next = (cnt_reg == two_n) ? S_CHK_A : S_ROOT_CHK;
            S_ROOT_CHK:
                state_next = (mark_q == MARK_NEW) ? S_ENTER_RD : S_ROOT_RD;
            S_ENTER_RD:
                state_next = S_ENTER_WR;
            S_ENTER_WR:
                state_next = S_STEP;
            S_STEP:
                if (e_reg != NULL_EDGE)
                    state_next = S_EDGE_D;
                else if (ordu_reg == lowu_reg)
                    state_next = S_POP_RD;
                else
                    state_next = S_AFTER;
            S_EDGE_D:
                state_next = S_EDGE_T;
            S_EDGE_T:
                state_next = (mark_q == MARK_NEW) ? S_ENTER_RD : S_STEP;
            S_POP_RD:
                state_next = S_POP_WR;
            S_POP_WR:
                state_next = (open_q != u_reg && od_reg != '0) ? S_POP_RD : S_AFTER;
            S_AFTER:
                state_next = (wd_reg != '0) ? S_PAR : S_ROOT_RD;
            S_PAR:
                state_next = S_PAR_D;
            S_PAR_D:
                state_next = S_STEP;
            S_CHK_A:
                state_next = S_CHK_B;
            S_CHK_B:
                state_next = S_CHK_C;
            S_CHK_C:
                if (comp_q == ca_reg || cnt_reg + CW'(1) == CW'(n_act))
                    state_next = S_RESULT;
                else
                    state_next = S_CHK_A;
            S_RESULT:
                if (!ov_reg || out_ready)
                    state_next = S_CLEAR;
            default:
                state_next = S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        nv_next   = nv_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        k_next    = k_reg;
        eidx_next = eidx_reg;
        last_next = last_reg;
        et_next   = et_reg;
        err_next  = err_reg;
        vc_next   = vc_reg;
        cc_next   = cc_reg;
        od_next   = od_reg;
        wd_next   = wd_reg;
        u_next    = u_reg;
        e_next    = e_reg;
        lowu_next = lowu_reg;
        ordu_next = ordu_reg;
        v_next    = v_reg;
        ca_next   = ca_reg;
        sat_next  = sat_reg;
        ov_next   = ov_reg;
        osat_next = osat_reg;
        ost_next  = ost_reg;

        edge_we  = 1'b0;
        head_we  = 1'b0;
        order_we = 1'b0;
        low_we   = 1'b0;
        mark_we  = 1'b0;
        comp_we  = 1'b0;
        open_we  = 1'b0;
        walk_we  = 1'b0;
        vaddr    = cnt_reg[VW-1:0];
        head_wa  = cnt_reg[VW-1:0];
        head_wd  = NULL_EDGE;
        order_wa = v_reg;
        order_wd = vc_reg + CW'(1);
        low_wa   = v_reg;
        low_wd   = vc_reg + CW'(1);
        mark_wa  = cnt_reg[VW-1:0];
        mark_wd  = MARK_NEW;
        comp_wa  = open_q;
        comp_wd  = cc_reg;
        open_wa  = od_reg[VW-1:0];
        open_wd  = v_reg;
        open_ra  = od_reg[VW-1:0] - VW'(1);
        walk_wa  = wd_reg[VW-1:0];
        walk_wd  = {u_reg, e_reg};
        walk_ra  = wd_reg[VW-1:0] - VW'(1);

        if (cfg_valid && cfg_ready)
            nv_next = cfg_data;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                head_we  = 1'b1;
                mark_we  = 1'b1;
                cnt_next = cnt_reg + CW'(1);
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    src_next  = es;
                    dst_next  = ed;
                    k_next    = ek;
                    eidx_next = '0;
                    last_next = last;
                    sat_next  = 1'b1;
                    cnt_next  = '0;
                    if (func != FUNC_NONE)
                    begin
                        if (bad_idx)
                        begin
                            if (err_reg == ST_OK)
                                err_next = ST_BAD_INDEX;
                        end
                        else if (et_sum > (EW+1)'(MAX_EDGES))
                        begin
                            if (err_reg == ST_OK)
                                err_next = ST_FULL;
                        end
                    end
                end
            end
            S_LOAD_RD:
            begin
                vaddr = src_reg[eidx_reg];
            end
            S_LOAD_WR:
            begin
                edge_we   = 1'b1;
                head_we   = 1'b1;
                head_wa   = src_reg[eidx_reg];
                head_wd   = et_reg;
                et_next   = et_reg + EW'(1);
                eidx_next = eidx_reg + 2'd1;
            end
            S_ROOT_RD:
            begin
                if (cnt_reg == two_n)
                    cnt_next = '0;
            end
            S_ROOT_CHK:
            begin
                if (mark_q == MARK_NEW)
                    v_next = cnt_reg[VW-1:0];
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_ENTER_RD:
            begin
                vaddr = v_reg;
            end
            S_ENTER_WR:
            begin
                vc_next   = vc_reg + CW'(1);
                order_we  = 1'b1;
                low_we    = 1'b1;
                mark_we   = 1'b1;
                mark_wa   = v_reg;
                mark_wd   = MARK_OPEN;
                open_we   = 1'b1;
                od_next   = od_reg + CW'(1);
                u_next    = v_reg;
                e_next    = head_q;
                lowu_next = vc_reg + CW'(1);
                ordu_next = vc_reg + CW'(1);
            end
            S_STEP:
            begin
                if (e_reg == NULL_EDGE && ordu_reg == lowu_reg)
                    cc_next = cc_reg + CW'(1);
            end
            S_EDGE_D:
            begin
                vaddr  = tgt_q;
                v_next = tgt_q;
                e_next = link_q;
            end
            S_EDGE_T:
            begin
                if (mark_q == MARK_NEW)
                begin
                    walk_we = 1'b1;
                    wd_next = wd_reg + CW'(1);
                    low_we  = 1'b1;
                    low_wa  = u_reg;
                    low_wd  = lowu_reg;
                end
                else if (mark_q == MARK_OPEN && order_q < lowu_reg)
                begin
                    lowu_next = order_q;
                end
            end
            S_POP_RD:
            begin
                od_next = od_reg - CW'(1);
            end
            S_POP_WR:
            begin
                mark_we = 1'b1;
                mark_wa = open_q;
                mark_wd = MARK_DONE;
                comp_we = 1'b1;
            end
            S_AFTER:
            begin
                if (wd_reg != '0)
                    wd_next = wd_reg - CW'(1);
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_PAR:
            begin
                vaddr  = walk_q[VW+EW-1:EW];
                u_next = walk_q[VW+EW-1:EW];
                e_next = walk_q[EW-1:0];
            end
            S_PAR_D:
            begin
                ordu_next = order_q;
                lowu_next = (lowu_reg < low_q) ? lowu_reg : low_q;
            end
            S_CHK_A:
            begin
                vaddr = cnt_reg[VW-1:0];
            end
            S_CHK_B:
            begin
                ca_next = comp_q;
                vaddr   = cnt_reg[VW-1:0] + VW'(n_act);
            end
            S_CHK_C:
            begin
                if (comp_q == ca_reg)
                    sat_next = 1'b0;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_RESULT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next   = 1'b1;
                    osat_next = sat_reg && (err_reg == ST_OK);
                    ost_next  = err_reg;
                    cnt_next  = '0;
                    et_next   = '0;
                    err_next  = ST_OK;
                    vc_next   = '0;
                    cc_next   = '0;
                    od_next   = '0;
                    wd_next   = '0;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_target_mem[et_reg[EIW-1:0]] <= dst_reg[eidx_reg];
            edge_link_mem[et_reg[EIW-1:0]]   <= head_q;
        end
        tgt_q  <= edge_target_mem[e_reg[EIW-1:0]];
        link_q <= edge_link_mem[e_reg[EIW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_q <= head_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
            order_mem[order_wa] <= order_wd;
        order_q <= order_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (low_we)
            low_mem[low_wa] <= low_wd;
        low_q <= low_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        mark_q <= mark_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (comp_we)
            comp_mem[comp_wa] <= comp_wd;
        comp_q <= comp_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (open_we)
            open_mem[open_wa] <= open_wd;
        open_q <= open_mem[open_ra];
    end

    always_ff @(posedge clk)
    begin
        if (walk_we)
            walk_mem[walk_wa] <= walk_wd;
        walk_q <= walk_mem[walk_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            nv_reg    <= NV_MAX;
            cnt_reg   <= '0;
            k_reg     <= '0;
            eidx_reg  <= '0;
            last_reg  <= 1'b0;
            et_reg    <= '0;
            err_reg   <= ST_OK;
            vc_reg    <= '0;
            cc_reg    <= '0;
            od_reg    <= '0;
            wd_reg    <= '0;
            sat_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nv_reg    <= nv_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            eidx_reg  <= eidx_next;
            last_reg  <= last_next;
            et_reg    <= et_next;
            err_reg   <= err_next;
            vc_reg    <= vc_next;
            cc_reg    <= cc_next;
            od_reg    <= od_next;
            wd_reg    <= wd_next;
            sat_reg   <= sat_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        u_reg    <= u_next;
        e_reg    <= e_next;
        lowu_reg <= lowu_next;
        ordu_reg <= ordu_next;
        v_reg    <= v_next;
        ca_reg   <= ca_next;
        osat_reg <= osat_next;
        ost_reg  <= ost_next;
    end

`ifndef ASSERT_OFF
    a_sat_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && satisfiable |-> status == ST_OK)
        else $error("satisfiable reported with error status");

    a_stacks_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> od_reg == '0 && wd_reg == '0)
        else $error("search stacks not empty while loading");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        et_reg <= EW'(MAX_EDGES))
        else $error("edge count beyond store size");
`endif

endmodule

// ----- tb/sv/two_sat_solver_tb.sv -----
`timescale 1ns / 1ps

module two_sat_solver_tb;
    import tss_pkg::*;

    typedef enum logic [1:0] {W_ITEM, W_CFG, W_PAUSE} word_kind_t;

    typedef struct {
        word_kind_t      kind;
        logic [1:0]      func;
        logic [AW-1:0]   a;
        logic [AW-1:0]   b;
        logic            c;
        logic            last;
        logic [NW-1:0]   cfg;
        int              gap;
    } word_t;

    typedef struct {
        logic       sat;
        logic [1:0] st;
    } verdict_t;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 2400;

    logic            clk = 0;
    logic            rst_n = 0;
    logic            cfg_valid = 0;
    logic            cfg_ready;
    logic [NW-1:0]   cfg_data = '0;
    logic            in_valid = 0;
    logic            in_ready;
    logic [1:0]      func = '0;
    logic [AW-1:0]   var_a = '0;
    logic [AW-1:0]   var_b = '0;
    logic            want_value = 0;
    logic            last = 0;
    logic            out_valid;
    logic            out_ready = 0;
    logic            satisfiable;
    logic [1:0]      status;

    two_sat_solver dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .var_a(var_a), .var_b(var_b),
        .want_value(want_value), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .satisfiable(satisfiable), .status(status)
    );

    word_t    pending_q[$];
    verdict_t verdict_q[$];
    int       errors = 0;
    int       cycles = 0;
    int       quiet = 0;

    // graph mirror
    int unsigned nv_reg;
    int          e_tgt[MAX_EDGES];
    int          e_lnk[MAX_EDGES];
    int          v_head[NVERT];
    int          v_ord[NVERT];
    int          v_low[NVERT];
    int          v_comp[NVERT];
    logic [1:0]  v_mark[NVERT];
    int          open_stk[NVERT];
    int          walk_v[NVERT];
    int          walk_e[NVERT];
    int          open_d, walk_d, edge_cnt, visit_cnt, comp_cnt;
    logic [1:0]  err_code;

    function automatic int active_vars();
        if (nv_reg == 0) return 1;
        if (nv_reg > MAX_VARS) return MAX_VARS;
        return nv_reg;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < NVERT; i++)
        begin
            v_head[i] = MAX_EDGES;
            v_mark[i] = MARK_NEW;
        end
        open_d = 0;
        walk_d = 0;
        edge_cnt = 0;
        visit_cnt = 0;
        comp_cnt = 0;
        err_code = ST_OK;
    endfunction

    function automatic void add_implications(logic [1:0] f, int a, int b, logic c);
        int n;
        int src[4];
        int dst[4];
        int k;
        int ta, tb, fa, fb;
        n = active_vars();
        k = 0;
        if (f == FUNC_NONE) return;
        if (a >= n || b >= n)
        begin
            if (err_code == ST_OK) err_code = ST_BAD_INDEX;
            return;
        end
        ta = a; tb = b; fa = a + n; fb = b + n;
        if (f == FUNC_AND)
        begin
            if (!c)
            begin
                src = '{ta, tb, 0, 0}; dst = '{fb, fa, 0, 0}; k = 2;
            end
            else
            begin
                src = '{ta, tb, fa, fb}; dst = '{tb, ta, ta, tb}; k = 4;
            end
        end
        else if (f == FUNC_OR)
        begin
            if (!c)
            begin
                src = '{fa, fb, ta, tb}; dst = '{fb, fa, fa, fb}; k = 4;
            end
            else
            begin
                src = '{fa, fb, 0, 0}; dst = '{tb, ta, 0, 0}; k = 2;
            end
        end
        else
        begin
            if (!c)
            begin
                src = '{ta, tb, fa, fb}; dst = '{tb, ta, fb, fa}; k = 4;
            end
            else
            begin
                src = '{fa, fb, ta, tb}; dst = '{tb, ta, fb, fa}; k = 4;
            end
        end
        if (edge_cnt + k > MAX_EDGES)
        begin
            if (err_code == ST_OK) err_code = ST_FULL;
            return;
        end
        for (int i = 0; i < k; i++)
        begin
            e_tgt[edge_cnt] = dst[i];
            e_lnk[edge_cnt] = v_head[src[i]];
            v_head[src[i]] = edge_cnt;
            edge_cnt++;
        end
    endfunction

    function automatic void enter_vertex(int v);
        visit_cnt++;
        v_ord[v] = visit_cnt;
        v_low[v] = visit_cnt;
        v_mark[v] = MARK_OPEN;
        open_stk[open_d] = v;
        open_d++;
        walk_v[walk_d] = v;
        walk_e[walk_d] = v_head[v];
        walk_d++;
    endfunction

    function automatic void search_from(int root);
        int u, e, t, x, p;
        enter_vertex(root);
        while (walk_d > 0)
        begin
            u = walk_v[walk_d-1];
            e = walk_e[walk_d-1];
            if (e < MAX_EDGES)
            begin
                t = e_tgt[e] % NVERT;
                walk_e[walk_d-1] = e_lnk[e];
                if (v_mark[t] == MARK_NEW)
                    enter_vertex(t);
                else if (v_mark[t] == MARK_OPEN && v_ord[t] < v_low[u])
                    v_low[u] = v_ord[t];
            end
            else
            begin
                walk_d--;
                if (v_ord[u] == v_low[u])
                begin
                    comp_cnt++;
                    do
                    begin
                        open_d--;
                        x = open_stk[open_d];
                        v_mark[x] = MARK_DONE;
                        v_comp[x] = comp_cnt;
                    end
                    while (x != u && open_d > 0);
                end
                if (walk_d > 0)
                begin
                    p = walk_v[walk_d-1];
                    if (v_low[u] < v_low[p]) v_low[p] = v_low[u];
                end
            end
        end
    endfunction

    function automatic logic graph_consistent();
        int n;
        n = active_vars();
        for (int i = 0; i < 2 * n; i++)
            if (v_mark[i] == MARK_NEW) search_from(i);
        for (int i = 0; i < n; i++)
            if (v_comp[i] == v_comp[i+n]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_word(word_t w);
        verdict_t r;
        add_implications(w.func, w.a, w.b, w.c);
        if (!w.last) return;
        r.sat = graph_consistent();
        if (err_code != ST_OK) r.sat = 1'b0;
        r.st = err_code;
        verdict_q = {verdict_q, r};
        clear_graph();
    endfunction

    function automatic void push_item(int f, int a, int b, int c, int l, int g);
        word_t w;
        w.kind = W_ITEM; w.func = 2'(f); w.a = AW'(a); w.b = AW'(b);
        w.c = 1'(c); w.last = 1'(l);
        w.cfg = '0; w.gap = g;
        pending_q = {pending_q, w};
    endfunction

    function automatic void push_ctl(word_kind_t k, int v);
        word_t w;
        w = '{kind: k, func: FUNC_NONE, a: '0, b: '0, c: 1'b0, last: 1'b0,
              cfg: NW'(v), gap: 0};
        pending_q = {pending_q, w};
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // driver
    word_t cur_word;
    int    send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic  nv, ncv;
        word_t hd;
        int    q;
        if (!rst_n)
        begin
            in_valid <= 0;
            cfg_valid <= 0;
            send_gap <= 0;
            quiet <= 0;
        end
        else
        begin
            nv = in_valid;
            ncv = cfg_valid;
            q = quiet + 1;
            if (in_valid && in_ready)
            begin
                predict_word(cur_word);
                nv = 0;
                q = 0;
            end
            if (out_valid && out_ready)
                q = 0;
            if (cfg_valid && cfg_ready)
            begin
                nv_reg = cfg_data;
                ncv = 0;
            end
            if (!nv && !ncv)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending_q.size() > 0)
                begin
                    hd = pending_q[0];
                    case (hd.kind)
                        W_ITEM:
                        begin
                            void'(pending_q.pop_front());
                            cur_word <= hd;
                            func <= hd.func;
                            var_a <= hd.a;
                            var_b <= hd.b;
                            want_value <= hd.c;
                            last <= hd.last;
                            nv = 1;
                            send_gap <= hd.gap;
                        end
                        W_CFG:
                            if (verdict_q.size() == 0 && quiet > SETTLE)
                            begin
                                void'(pending_q.pop_front());
                                cfg_data <= hd.cfg;
                                ncv = 1;
                            end
                        default:
                            if (verdict_q.size() == 0)
                                void'(pending_q.pop_front());
                    endcase
                end
            end
            quiet <= q;
            in_valid <= nv;
            cfg_valid <= ncv;
        end
    end

    // monitor
    int  recv_wait = 0;
    int  verdicts_seen = 0;
    bit  calm_recv = 0;

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t ex;
        logic     nr;
        int       w;
        if (!rst_n)
        begin
            out_ready <= 0;
            recv_wait <= 0;
        end
        else
        begin
            nr = out_ready;
            w = recv_wait;
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected word sat=%0d status=%0d",
                             $time, satisfiable, status);
                    errors++;
                end
                else
                begin
                    ex = verdict_q.pop_front();
                    if (satisfiable !== ex.sat)
                    begin
                        $display("%0t: satisfiable expected %0d actual %0d",
                                 $time, ex.sat, satisfiable);
                        errors++;
                    end
                    if (status !== ex.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, ex.st, status);
                        errors++;
                    end
                end
                verdicts_seen++;
                if (verdicts_seen % 20 == 0) calm_recv = !calm_recv;
                if (verdicts_seen == 23)
                    w = 12000;
                else
                    w = calm_recv ? 0 : $urandom_range(0, 6);
                nr = (w == 0);
            end
            else if (w > 0)
            begin
                w--;
                nr = (w == 0);
            end
            else
                nr = 1;
            recv_wait <= w;
            out_ready <= nr;
        end
    end

    // stimulus and end of run
    initial
    begin
        int n, k, fa, fb, total, nprob;
        bit calm, noise;
        nv_reg = MAX_VARS;
        clear_graph();

        push_ctl(W_CFG, 4);
        push_item(FUNC_AND, 0, 1, 1, 0, 0);
        push_item(FUNC_AND, 2, 3, 0, 0, 1);
        push_item(FUNC_OR, 0, 2, 1, 0, 0);
        push_item(FUNC_OR, 1, 3, 0, 0, 2);
        push_item(FUNC_XOR, 0, 3, 0, 0, 0);
        push_item(FUNC_XOR, 1, 2, 1, 0, 0);
        push_item(FUNC_NONE, 1023, 1023, 1, 1, 3);
        push_item(FUNC_XOR, 2, 2, 1, 1, 0);
        push_item(FUNC_AND, 5, 0, 0, 0, 0);
        push_item(FUNC_OR, 1, 2, 1, 0, 0);
        push_item(FUNC_XOR, 0, 1023, 0, 1, 0);
        push_item(FUNC_OR, 3, 3, 0, 1, 0);
        push_ctl(W_CFG, 0);
        push_item(FUNC_AND, 0, 0, 1, 1, 0);
        push_item(FUNC_OR, 0, 1, 1, 1, 0);
        push_ctl(W_CFG, 1);
        push_item(FUNC_NONE, 1023, 512, 0, 0, 0);
        push_item(FUNC_AND, 0, 0, 0, 1, 0);
        push_ctl(W_CFG, 2047);
        push_item(FUNC_XOR, 1023, 0, 1, 0, 0);
        push_item(FUNC_AND, 1023, 1023, 1, 0, 0);
        push_item(FUNC_OR, 512, 0, 0, 1, 0);
        push_ctl(W_CFG, MAX_VARS);
        for (int i = 0; i < MAX_EDGES / 4 + 2; i++)
            push_item(FUNC_XOR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1), 0, 0);
        push_item(FUNC_AND, 7, 9, 1, 1, 0);

        total = 0;
        nprob = 0;
        n = 8;
        push_ctl(W_CFG, n);
        while (total < 950)
        begin
            if (nprob % 12 == 11)
            begin
                if (nprob == 59)
                    n = MAX_VARS;
                else
                    n = $urandom_range(1, 40);
                push_ctl(W_CFG, n);
            end
            if (nprob == 30) push_ctl(W_PAUSE, 0);
            calm = ($urandom_range(0, 9) < 3);
            k = $urandom_range(1, 12);
            for (int j = 0; j < k; j++)
            begin
                noise = ($urandom_range(0, 9) == 0);
                fa = $urandom_range(0, n > 1024 ? 1023 : n - 1);
                fb = $urandom_range(0, n > 1024 ? 1023 : n - 1);
                if (noise)
                begin
                    if ($urandom_range(0, 1)) fa = $urandom_range(0, 1023);
                    else fb = $urandom_range(0, 1023);
                end
                push_item(noise && $urandom_range(0, 1) ? FUNC_NONE : $urandom_range(0, 2),
                          fa, fb, $urandom_range(0, 1), j == k - 1,
                          calm ? 0 : $urandom_range(0, 6));
                total++;
            end
            nprob++;
        end
        push_ctl(W_CFG, MAX_VARS);

        wait (rst_n);
        @(posedge clk);
        while (pending_q.size() > 0 || in_valid || cfg_valid || verdict_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tss_pkg.sv
rtl/two_sat_solver.sv
tb/sv/two_sat_solver_tb.sv
